// ===== design/e2r_pkg.sv =====
// Shared constants, types and arithmetic helpers for the Euler-to-rotation-matrix block.
package e2r_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int ELEMENT_BITS  = 16;
  localparam int WORD_W        = 32;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int WIDE_W        = 64;
  localparam int Q_FRAC        = 30;
  localparam int CORDIC_STEPS  = 24;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int LANES         = 3;
  localparam int MATRIX_STAGES = 4;
  localparam int PIPE_DEPTH    = CORDIC_STEPS + MATRIX_STAGES;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [WORD_W-1:0] CORDIC_X0 = 32'sd652032874;

  localparam logic [WORD_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int ELEM_FRAC = ELEMENT_BITS - 1;
  localparam int RIGHT_SH  = (ELEM_FRAC < Q_FRAC) ? Q_FRAC - ELEM_FRAC : 0;
  localparam int LEFT_SH   = (ELEM_FRAC > Q_FRAC) ? ELEM_FRAC - Q_FRAC : 0;
  localparam logic signed [WIDE_W-1:0] ROUND_ADD =
    (RIGHT_SH > 0) ? (64'sd1 <<< (RIGHT_SH - 1)) : 64'sd0;
  localparam logic signed [WIDE_W-1:0] EL_MAX = (64'sd1 <<< ELEM_FRAC) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] EL_MIN = -(64'sd1 <<< ELEM_FRAC);

  typedef logic signed [WORD_W-1:0]       word_t;
  typedef logic signed [WORD_W:0]         sum_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [WIDE_W-1:0]       wide_t;
  typedef logic signed [ELEMENT_BITS-1:0] element_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic  [LANES-1:0] flip;
  } cordic_t;

  // Q2.30 product with round half up.
  function automatic word_t qmul(word_t a, word_t b);
    prod_t p;
    p = prod_t'(a) * prod_t'(b) + (prod_t'(1) <<< (Q_FRAC - 1));
    return word_t'(p >>> Q_FRAC);
  endfunction

  // Rounds a Q2.30 value to the element format and saturates it.
  function automatic element_t to_element(sum_t v);
    wide_t r;
    r = ((wide_t'(v) + ROUND_ADD) >>> RIGHT_SH) <<< LEFT_SH;
    if (r > EL_MAX) begin
      r = EL_MAX;
    end
    if (r < EL_MIN) begin
      r = EL_MIN;
    end
    return element_t'(r);
  endfunction

  function automatic word_t neg_if(word_t v, logic neg);
    return neg ? word_t'(-v) : v;
  endfunction

endpackage

// ===== design/e2r_ifs.sv =====
// Valid/ready channel interfaces for angle triples and rotation matrices.
interface e2r_angle_if;
  logic valid;
  logic ready;
  logic signed [e2r_pkg::ANGLE_BITS-1:0] roll_angle;
  logic signed [e2r_pkg::ANGLE_BITS-1:0] pitch_angle;
  logic signed [e2r_pkg::ANGLE_BITS-1:0] yaw_angle;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2r_matrix_if;
  logic valid;
  logic ready;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m00;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m01;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m02;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m10;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m11;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m12;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m20;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m21;
  logic signed [e2r_pkg::ELEMENT_BITS-1:0] m22;

  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ===== design/e2r_cordic_cell.sv =====
// One CORDIC rotation step for all three angles, with its own pipeline register.
module e2r_cordic_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [e2r_pkg::STEP_W-1:0] step,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  e2r_pkg::cordic_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output e2r_pkg::cordic_t           out_data
);

  e2r_pkg::cordic_t data_next;

  always_comb begin
    e2r_pkg::word_t x;
    e2r_pkg::word_t y;
    e2r_pkg::word_t z;
    e2r_pkg::word_t dx;
    e2r_pkg::word_t dy;
    e2r_pkg::word_t atan;
    data_next = in_data;
    atan = e2r_pkg::word_t'(e2r_pkg::ATAN_TURN[step]);
    for (int l = 0; l < e2r_pkg::LANES; l++) begin
      x  = e2r_pkg::word_t'(in_data.lane[l].x);
      y  = e2r_pkg::word_t'(in_data.lane[l].y);
      z  = e2r_pkg::word_t'(in_data.lane[l].z);
      dx = y >>> step;
      dy = x >>> step;
      if (!z[e2r_pkg::WORD_W-1]) begin
        data_next.lane[l].x = x - dx;
        data_next.lane[l].y = y + dy;
        data_next.lane[l].z = z - atan;
      end else begin
        data_next.lane[l].x = x + dx;
        data_next.lane[l].y = y - dy;
        data_next.lane[l].z = z + atan;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/e2r_cordic_chain.sv =====
// Angle folding and the row of CORDIC cells that forms sines and cosines.
module e2r_cordic_chain (
  input  logic             clk,
  input  logic             rst,
  e2r_angle_if.sink        angles,
  output logic             out_valid,
  input  logic             out_ready,
  output e2r_pkg::cordic_t out_data
);

  localparam int ALIGN_SH = e2r_pkg::WORD_W - e2r_pkg::ANGLE_BITS;

  logic [e2r_pkg::CORDIC_STEPS:0] valid;
  logic [e2r_pkg::CORDIC_STEPS:0] ready;
  e2r_pkg::cordic_t               data [e2r_pkg::CORDIC_STEPS+1];
  logic [e2r_pkg::ANGLE_BITS-1:0] ang [e2r_pkg::LANES];

  assign ang[e2r_pkg::LANE_ROLL]  = angles.roll_angle;
  assign ang[e2r_pkg::LANE_PITCH] = angles.pitch_angle;
  assign ang[e2r_pkg::LANE_YAW]   = angles.yaw_angle;

  // Angles outside the right half plane are turned by half a turn, and their
  // sine and cosine are negated later, in the sign correction of the matrix block.
  always_comb begin
    logic [e2r_pkg::WORD_W-1:0] w;
    logic                       fl;
    data[0] = '0;
    for (int l = 0; l < e2r_pkg::LANES; l++) begin
      w  = e2r_pkg::WORD_W'(ang[l]) << ALIGN_SH;
      fl = w[e2r_pkg::WORD_W-1] ^ w[e2r_pkg::WORD_W-2];
      data[0].lane[l].x = e2r_pkg::CORDIC_X0;
      data[0].lane[l].y = '0;
      data[0].lane[l].z = {w[e2r_pkg::WORD_W-1] ^ fl, w[e2r_pkg::WORD_W-2:0]};
      data[0].flip[l]   = fl;
    end
  end

  assign valid[0]     = angles.valid;
  assign angles.ready = ready[0];

  for (genvar i = 0; i < e2r_pkg::CORDIC_STEPS; i++) begin : g_cell
    e2r_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (e2r_pkg::STEP_W'(i)),
      .in_valid (valid[i]),
      .in_ready (ready[i]),
      .in_data  (data[i]),
      .out_valid(valid[i+1]),
      .out_ready(ready[i+1]),
      .out_data (data[i+1])
    );
  end

  assign out_valid                   = valid[e2r_pkg::CORDIC_STEPS];
  assign ready[e2r_pkg::CORDIC_STEPS] = out_ready;
  assign out_data                    = data[e2r_pkg::CORDIC_STEPS];

endmodule

// ===== design/e2r_matrix.sv =====
// Sign correction, products and element rounding that build the rotation matrix.
module e2r_matrix (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  e2r_pkg::cordic_t in_data,
  e2r_matrix_if.source     matrix
);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  e2r_pkg::word_t sr1, cr1, sp1, cp1, sy1, cy1;
  e2r_pkg::word_t sr2, cr2, sp2;
  e2r_pkg::word_t cysp2, sysp2, cycp2, sycp2, cpsr2, cpcr2, sycr2, sysr2, cycr2, cysr2;
  e2r_pkg::word_t sp3, cycp3, sycp3, cpsr3, cpcr3, sycr3, sysr3, cycr3, cysr3;
  e2r_pkg::word_t cyspsr3, cyspcr3, syspsr3, syspcr3;
  e2r_pkg::element_t e00, e01, e02, e10, e11, e12, e20, e21, e22;

  assign rdy4     = !v4 || matrix.ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sr1 <= e2r_pkg::neg_if(in_data.lane[e2r_pkg::LANE_ROLL].y,
                             in_data.flip[e2r_pkg::LANE_ROLL]);
      cr1 <= e2r_pkg::neg_if(in_data.lane[e2r_pkg::LANE_ROLL].x,
                             in_data.flip[e2r_pkg::LANE_ROLL]);
      sp1 <= e2r_pkg::neg_if(in_data.lane[e2r_pkg::LANE_PITCH].y,
                             in_data.flip[e2r_pkg::LANE_PITCH]);
      cp1 <= e2r_pkg::neg_if(in_data.lane[e2r_pkg::LANE_PITCH].x,
                             in_data.flip[e2r_pkg::LANE_PITCH]);
      sy1 <= e2r_pkg::neg_if(in_data.lane[e2r_pkg::LANE_YAW].y,
                             in_data.flip[e2r_pkg::LANE_YAW]);
      cy1 <= e2r_pkg::neg_if(in_data.lane[e2r_pkg::LANE_YAW].x,
                             in_data.flip[e2r_pkg::LANE_YAW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      sr2   <= sr1;
      cr2   <= cr1;
      sp2   <= sp1;
      cysp2 <= e2r_pkg::qmul(cy1, sp1);
      sysp2 <= e2r_pkg::qmul(sy1, sp1);
      cycp2 <= e2r_pkg::qmul(cy1, cp1);
      sycp2 <= e2r_pkg::qmul(sy1, cp1);
      cpsr2 <= e2r_pkg::qmul(cp1, sr1);
      cpcr2 <= e2r_pkg::qmul(cp1, cr1);
      sycr2 <= e2r_pkg::qmul(sy1, cr1);
      sysr2 <= e2r_pkg::qmul(sy1, sr1);
      cycr2 <= e2r_pkg::qmul(cy1, cr1);
      cysr2 <= e2r_pkg::qmul(cy1, sr1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      sp3     <= sp2;
      cycp3   <= cycp2;
      sycp3   <= sycp2;
      cpsr3   <= cpsr2;
      cpcr3   <= cpcr2;
      sycr3   <= sycr2;
      sysr3   <= sysr2;
      cycr3   <= cycr2;
      cysr3   <= cysr2;
      cyspsr3 <= e2r_pkg::qmul(cysp2, sr2);
      cyspcr3 <= e2r_pkg::qmul(cysp2, cr2);
      syspsr3 <= e2r_pkg::qmul(sysp2, sr2);
      syspcr3 <= e2r_pkg::qmul(sysp2, cr2);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      e00 <= e2r_pkg::to_element(e2r_pkg::sum_t'(cycp3));
      e01 <= e2r_pkg::to_element(e2r_pkg::sum_t'(cyspsr3) - e2r_pkg::sum_t'(sycr3));
      e02 <= e2r_pkg::to_element(e2r_pkg::sum_t'(cyspcr3) + e2r_pkg::sum_t'(sysr3));
      e10 <= e2r_pkg::to_element(e2r_pkg::sum_t'(sycp3));
      e11 <= e2r_pkg::to_element(e2r_pkg::sum_t'(syspsr3) + e2r_pkg::sum_t'(cycr3));
      e12 <= e2r_pkg::to_element(e2r_pkg::sum_t'(syspcr3) - e2r_pkg::sum_t'(cysr3));
      e20 <= e2r_pkg::to_element(-e2r_pkg::sum_t'(sp3));
      e21 <= e2r_pkg::to_element(e2r_pkg::sum_t'(cpsr3));
      e22 <= e2r_pkg::to_element(e2r_pkg::sum_t'(cpcr3));
    end
  end

  assign matrix.valid = v4;
  assign matrix.m00   = e00;
  assign matrix.m01   = e01;
  assign matrix.m02   = e02;
  assign matrix.m10   = e10;
  assign matrix.m11   = e11;
  assign matrix.m12   = e12;
  assign matrix.m20   = e20;
  assign matrix.m21   = e21;
  assign matrix.m22   = e22;

endmodule

// ===== design/euler_to_rotation_matrix_top.sv =====
// Top level of the Euler ZYX angle to rotation matrix converter.
//
// The angles channel takes one roll, pitch and yaw triple per item, each a
// signed binary angle where the full field range is one turn. The matrix
// channel returns one item per input item: the nine elements of
// Rz(yaw) * Ry(pitch) * Rx(roll) as signed Q1.15 values, in input order.
// An accepted input item passes through the row of CORDIC cells, then through
// sign correction, two product stages and rounding. Throughput is one item per
// cycle while the receiver does not stall the matrix channel.
// Every stage has its own valid bit, so a stalled receiver holds only the
// output register; earlier stages keep filling empty slots and the angles
// channel stays ready until the whole pipeline is full.
// A synchronous reset clears all valid bits and drops items in flight.
module euler_to_rotation_matrix_top (
  input  logic         clk,
  input  logic         rst,
  e2r_angle_if.sink    angles,
  e2r_matrix_if.source matrix
);

  logic             trig_valid;
  logic             trig_ready;
  e2r_pkg::cordic_t trig_data;

  e2r_cordic_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .angles   (angles),
    .out_valid(trig_valid),
    .out_ready(trig_ready),
    .out_data (trig_data)
  );

  e2r_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .in_valid(trig_valid),
    .in_ready(trig_ready),
    .in_data (trig_data),
    .matrix  (matrix)
  );

endmodule

// ===== design/e2r_checker.sv =====
// Port-level assertions for the Euler-to-rotation-matrix block and their binding.
module e2r_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [9*e2r_pkg::ELEMENT_BITS-1:0]   out_data
);

  localparam int OCC_W = $clog2(e2r_pkg::PIPE_DEPTH + 1);

  logic [OCC_W-1:0] occupancy;
  logic             in_fire;
  logic             out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (in_fire && !out_fire) begin
      occupancy <= occupancy + OCC_W'(1);
    end else if (!in_fire && out_fire) begin
      occupancy <= occupancy - OCC_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled output item changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy != '0)
    else $error("output item with no input item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(e2r_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

endmodule

bind euler_to_rotation_matrix_top e2r_checker u_e2r_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (angles.valid),
  .in_ready (angles.ready),
  .out_valid(matrix.valid),
  .out_ready(matrix.ready),
  .out_data ({matrix.m00, matrix.m01, matrix.m02,
              matrix.m10, matrix.m11, matrix.m12,
              matrix.m20, matrix.m21, matrix.m22})
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the Euler ZYX angle to rotation matrix converter with a CORDIC predictor.
module tb_top;

  localparam int AW             = e2r_pkg::ANGLE_BITS;
  localparam int EW             = e2r_pkg::ELEMENT_BITS;
  localparam int LATENCY        = 28;
  localparam int CORDIC_STEPS   = 24;
  localparam int N_DIRECTED     = 20;
  localparam int N_RANDOM       = 430;
  localparam int STALL_AT       = 60;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 40;
  localparam int ROUND_SH       = 31 - EW;

  localparam longint Q30_ONE   = 64'sd1 <<< 30;
  localparam longint UNIT_GAIN = 64'sd652032874;

  localparam longint ATAN_Q32 [CORDIC_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef logic [AW-1:0] angle_t;
  typedef logic [EW-1:0] element_t;
  typedef logic [8:0][EW-1:0] matrix_t;

  localparam element_t E_MAX  = EW'((1 << (EW - 1)) - 1);
  localparam element_t E_MIN  = EW'(1 << (EW - 1));
  localparam element_t E_ZERO = '0;

  // Elements are packed m22 first, so that index 0 is m00.
  localparam matrix_t IDENTITY = {E_MAX, E_ZERO, E_ZERO, E_ZERO, E_MAX, E_ZERO,
                                  E_ZERO, E_ZERO, E_MAX};
  localparam matrix_t ROLL_PI  = {E_MIN, E_ZERO, E_ZERO, E_ZERO, E_MIN, E_ZERO,
                                  E_ZERO, E_ZERO, E_MAX};
  localparam matrix_t PITCH_PI = {E_MIN, E_ZERO, E_ZERO, E_ZERO, E_MAX, E_ZERO,
                                  E_ZERO, E_ZERO, E_MIN};
  localparam matrix_t YAW_PI   = {E_MAX, E_ZERO, E_ZERO, E_ZERO, E_MIN, E_ZERO,
                                  E_ZERO, E_ZERO, E_MIN};

  typedef struct packed {
    angle_t  roll;
    angle_t  pitch;
    angle_t  yaw;
    logic    known;
    matrix_t want;
  } angle_row_t;

  localparam angle_row_t ANGLE_TABLE [N_DIRECTED] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, IDENTITY},
    '{16'h8000, 16'h0000, 16'h0000, 1'b1, ROLL_PI},
    '{16'h0000, 16'h8000, 16'h0000, 1'b1, PITCH_PI},
    '{16'h0000, 16'h0000, 16'h8000, 1'b1, YAW_PI},
    '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
    '{16'h4000, 16'h0000, 16'h0000, 1'b0, '0},
    '{16'h0000, 16'h4000, 16'h0000, 1'b0, '0},
    '{16'h0000, 16'h0000, 16'h4000, 1'b0, '0},
    '{16'hC000, 16'hC000, 16'hC000, 1'b0, '0},
    '{16'h3FFF, 16'hBFFF, 16'h4001, 1'b0, '0},
    '{16'hC001, 16'h4000, 16'h3FFF, 1'b0, '0},
    '{16'h0001, 16'hFFFF, 16'h0001, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0},
    '{16'h2000, 16'h1000, 16'hE000, 1'b0, '0},
    '{16'h1234, 16'hED00, 16'h6000, 1'b0, '0},
    '{16'h7FFF, 16'h8000, 16'h0001, 1'b0, '0},
    '{16'h8001, 16'h7FFF, 16'hC000, 1'b0, '0}
  };

  logic clk;
  logic rst;

  e2r_angle_if  angles_ch ();
  e2r_matrix_if matrix_ch ();

  euler_to_rotation_matrix_top DUT (
    .clk    (clk),
    .rst    (rst),
    .angles (angles_ch),
    .matrix (matrix_ch)
  );

  matrix_t pending_matrices [$];
  string   element_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
  int      n_sent      = 0;
  int      n_received  = 0;
  int      n_errors    = 0;
  int      idle_cycles = 0;

  function automatic void sin_cos_q30(angle_t ang, output longint sn, output longint cs);
    int     word;
    longint a;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    int     i;
    word = {ang, {(32 - AW){1'b0}}};
    a    = word;
    flip = (a >= Q30_ONE) || (a < -Q30_ONE);
    if (flip) begin
      a = (a > 0) ? a - 2 * Q30_ONE : a + 2 * Q30_ONE;
    end
    x = UNIT_GAIN;
    y = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x = x - dx;
        y = y + dy;
        a = a - ATAN_Q32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        a = a + ATAN_Q32[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic element_t round_element(longint v);
    longint r;
    r = (v + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
    if (r > longint'((1 << (EW - 1)) - 1)) begin
      r = (1 << (EW - 1)) - 1;
    end
    if (r < -longint'(1 << (EW - 1))) begin
      r = -longint'(1 << (EW - 1));
    end
    return element_t'(r);
  endfunction

  function automatic matrix_t rotation_from_angles(angle_t roll, angle_t pitch, angle_t yaw);
    longint  sr;
    longint  cr;
    longint  sp;
    longint  cp;
    longint  sy;
    longint  cy;
    longint  cysp;
    longint  sysp;
    matrix_t m;
    sin_cos_q30(roll, sr, cr);
    sin_cos_q30(pitch, sp, cp);
    sin_cos_q30(yaw, sy, cy);
    cysp = mul_q30(cy, sp);
    sysp = mul_q30(sy, sp);
    m[0] = round_element(mul_q30(cy, cp));
    m[1] = round_element(mul_q30(cysp, sr) - mul_q30(sy, cr));
    m[2] = round_element(mul_q30(cysp, cr) + mul_q30(sy, sr));
    m[3] = round_element(mul_q30(sy, cp));
    m[4] = round_element(mul_q30(sysp, sr) + mul_q30(cy, cr));
    m[5] = round_element(mul_q30(sysp, cr) - mul_q30(cy, sr));
    m[6] = round_element(-sp);
    m[7] = round_element(mul_q30(cp, sr));
    m[8] = round_element(mul_q30(cp, cr));
    return m;
  endfunction

  // Half the draws are uniform, the rest sit near the quadrant folds or near zero.
  function automatic angle_t pick_angle();
    int kind;
    kind = $urandom_range(0, 5);
    if (kind < 3) begin
      return angle_t'($urandom);
    end
    if (kind < 5) begin
      return angle_t'(($urandom_range(0, 3) << (AW - 2)) + $urandom_range(0, 8) - 4);
    end
    return angle_t'($urandom_range(0, 64) - 32);
  endfunction

  task automatic send_angles(angle_t roll, angle_t pitch, angle_t yaw, logic known,
                             matrix_t want);
    int gap;
    gap = ((n_sent / 24) % 3 == 2) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      angles_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    angles_ch.valid       <= 1'b1;
    angles_ch.roll_angle  <= roll;
    angles_ch.pitch_angle <= pitch;
    angles_ch.yaw_angle   <= yaw;
    @(posedge clk);
    while (!angles_ch.ready) @(posedge clk);
    pending_matrices.insert(pending_matrices.size(),
                            known ? want : rotation_from_angles(roll, pitch, yaw));
    n_sent++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : angle_source
    int i;
    rst                   = 1'b1;
    angles_ch.valid       = 1'b0;
    angles_ch.roll_angle  = '0;
    angles_ch.pitch_angle = '0;
    angles_ch.yaw_angle   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (i = 0; i < N_DIRECTED; i++) begin
      send_angles(ANGLE_TABLE[i].roll, ANGLE_TABLE[i].pitch, ANGLE_TABLE[i].yaw,
                  ANGLE_TABLE[i].known, ANGLE_TABLE[i].want);
    end
    for (i = 0; i < N_RANDOM; i++) begin
      send_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, '0);
    end
    angles_ch.valid <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 12) @(posedge clk);
    $display("Sent %0d angle triples (%0d from the table, %0d random), checked %0d matrices,",
             n_sent, N_DIRECTED, N_RANDOM, n_received);
    $display("with random gaps on both sides and one output stall of %0d cycles.", STALL_CYCLES);
    if (n_errors == 0) begin
      $display("[euler_to_rotation_matrix_top] OK");
    end else begin
      $display("[euler_to_rotation_matrix_top] ERROR");
    end
    $finish;
  end

  initial begin : matrix_sink
    int gap;
    bit stalled;
    matrix_ch.ready = 1'b0;
    stalled         = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!stalled && n_received >= STALL_AT) begin
        gap     = STALL_CYCLES;
        stalled = 1'b1;
      end else begin
        gap = ((n_received / 20) % 3 == 1) ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        matrix_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      matrix_ch.ready <= 1'b1;
      @(posedge clk);
      while (!matrix_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : matrix_check
    matrix_t got;
    matrix_t want;
    int      k;
    if (!rst && matrix_ch.valid && matrix_ch.ready) begin
      got = {matrix_ch.m22, matrix_ch.m21, matrix_ch.m20, matrix_ch.m12, matrix_ch.m11,
             matrix_ch.m10, matrix_ch.m02, matrix_ch.m01, matrix_ch.m00};
      n_received++;
      if (pending_matrices.size() == 0) begin
        n_errors++;
        $display("%0t: matrix item arrived with none outstanding", $time);
      end else begin
        want = pending_matrices.pop_front();
        for (k = 0; k < 9; k++) begin
          if (got[k] !== want[k]) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("%0t: %s expected %0d got %0d", $time, element_name[k],
                       $signed(want[k]), $signed(got[k]));
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((angles_ch.valid && angles_ch.ready) || (matrix_ch.valid && matrix_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("[euler_to_rotation_matrix_top] ERROR");
      $finish;
    end
  end

endmodule

// ===== files.f =====
design/e2r_pkg.sv
design/e2r_ifs.sv
design/e2r_cordic_cell.sv
design/e2r_cordic_chain.sv
design/e2r_matrix.sv
design/euler_to_rotation_matrix_top.sv
design/e2r_checker.sv
dv/tb_top.sv
